>>> hw/rtl/nlp_pkg.sv
// Package for the next-permutation block: shared types.
// No dependencies.
package nlp_pkg;
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } t_in;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
        logic       no_answer;
        logic       overflow;
    } t_out;

    // Command passed from the loader to the engine through the queue.
    typedef struct packed {
        logic [6:0] len;
        logic       ovf;
        logic       bank;
    } t_cmd;
endpackage

>>> hw/rtl/nlp_if.sv
// Valid/ready channel interface carrying one payload struct.
// No dependencies; the payload type is a parameter.
interface nlp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/nlp_eng.sv
// Back end: pivot search, swap, suffix reversal and emit over a memory.
// Depends on nlp_pkg and nlp_if.
module nlp_eng import nlp_pkg::*; #(
    parameter int AW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // memory write port from loader
    input  logic          i_wr_en,
    input  logic          i_wr_bank,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    // high while the engine owns the memory write port
    output logic          o_wr_busy,
    // command queue head; popped once the string is fully emitted
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_cmd_pop,
    nlp_if.source         o_res
);
    localparam logic [3:0] S_IDLE = 4'd0, S_PRD = 4'd1, S_PCMP = 4'd2,
        S_JRD = 4'd3, S_JCMP = 4'd4, S_SWA = 4'd5, S_SWB = 4'd6,
        S_RRD = 4'd7, S_RWA = 4'd8, S_RWB = 4'd9, S_ORD = 4'd10,
        S_OUT = 4'd11, S_NONE = 4'd12;

    logic [7:0] r_mem [0:2**(AW+1)-1];
    logic [AW:0] r_raddr;
    logic [7:0] r_rdata;
    logic       w_en;
    logic [AW:0] w_addr;
    logic [7:0] w_data;

    logic [3:0]    r_st;
    logic [AW-1:0] r_i, r_j, r_n;
    logic [7:0]    r_a, r_b, r_piv;
    logic          r_bank, r_ovf, r_first;
    logic          r_ov;
    t_out          r_res;

    always_ff @(posedge i_clk) begin
        if (w_en) r_mem[w_addr] <= w_data;
        else if (i_wr_en) r_mem[{i_wr_bank, i_wr_addr}] <= i_wr_data;
        r_rdata <= r_mem[r_raddr];
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_res;
    assign o_wr_busy   = w_en;

    always_comb begin
        w_en = 1'b0;
        w_addr = {r_bank, r_i};
        w_data = r_b;
        o_cmd_pop = 1'b0;
        case (r_st)
            S_SWA: begin w_en = 1'b1; w_addr = {r_bank, r_i}; w_data = r_b; end
            S_SWB: begin w_en = 1'b1; w_addr = {r_bank, r_j}; w_data = r_piv; end
            // r_rdata holds the high byte of the pair here
            S_RWA: begin w_en = 1'b1; w_addr = {r_bank, r_i}; w_data = r_rdata; end
            S_RWB: begin w_en = 1'b1; w_addr = {r_bank, r_j}; w_data = r_a; end
            S_OUT: begin
                if ((!r_ov || o_res.ready) && (r_i == r_n - 1'b1)) o_cmd_pop = 1'b1;
            end
            S_NONE: begin
                if (!r_ov || o_res.ready) o_cmd_pop = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && o_res.ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (i_cmd_valid) begin
                    r_bank <= i_cmd.bank;
                    r_ovf  <= i_cmd.ovf;
                    r_n    <= i_cmd.len[AW-1:0];
                    if (i_cmd.len < 7'd2) r_st <= S_NONE;
                    else begin
                        r_i <= AW'(i_cmd.len - 7'd1);
                        r_raddr <= {i_cmd.bank, AW'(i_cmd.len - 7'd1)};
                        r_first <= 1'b1;
                        r_st <= S_PRD;
                    end
                end
                // scan down: r_b holds s[i+1], read s[i]
                S_PRD: begin
                    r_st <= S_PCMP;
                end
                S_PCMP: begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_b <= r_rdata;
                        r_i <= r_i - 1'b1;
                        r_raddr <= {r_bank, r_i - 1'b1};
                        r_st <= S_PRD;
                    end else if (r_rdata < r_b) begin
                        r_piv <= r_rdata;
                        r_j <= r_n - 1'b1;
                        r_raddr <= {r_bank, r_n - 1'b1};
                        r_st <= S_JRD;
                    end else if (r_i == '0) begin
                        r_st <= S_NONE;
                    end else begin
                        r_b <= r_rdata;
                        r_i <= r_i - 1'b1;
                        r_raddr <= {r_bank, r_i - 1'b1};
                        r_st <= S_PRD;
                    end
                end
                S_JRD: r_st <= S_JCMP;
                S_JCMP: begin
                    if (r_rdata > r_piv) begin
                        r_b <= r_rdata;
                        r_st <= S_SWA;
                    end else begin
                        r_j <= r_j - 1'b1;
                        r_raddr <= {r_bank, r_j - 1'b1};
                        r_st <= S_JRD;
                    end
                end
                S_SWA: r_st <= S_SWB;
                S_SWB: begin
                    r_i <= r_i + 1'b1;
                    r_j <= r_n - 1'b1;
                    r_st <= S_RRD;
                    r_first <= 1'b1;
                    r_raddr <= {r_bank, r_i + 1'b1};
                end
                // reverse: read lo into r_a, hi into r_b, write back swapped
                S_RRD: begin
                    if (r_i >= r_j) begin
                        r_i <= '0;
                        r_raddr <= {r_bank, {AW{1'b0}}};
                        r_st <= S_ORD;
                    end else if (r_first) begin
                        r_first <= 1'b0;
                        r_raddr <= {r_bank, r_j};
                    end else begin
                        r_a <= r_rdata;
                        r_st <= S_RWA;
                    end
                end
                S_RWA: begin
                    r_b <= r_rdata;
                    r_st <= S_RWB;
                end
                S_RWB: begin
                    r_i <= r_i + 1'b1;
                    r_j <= r_j - 1'b1;
                    r_raddr <= {r_bank, r_i + 1'b1};
                    r_first <= 1'b1;
                    r_st <= S_RRD;
                end
                S_ORD: begin
                    // wait for read data, then an output slot
                    if (!r_ov || o_res.ready) begin
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov <= 1'b1;
                        r_res.char_out  <= r_rdata;
                        r_res.last_out  <= (r_i == r_n - 1'b1);
                        r_res.no_answer <= 1'b0;
                        r_res.overflow  <= r_ovf;
                        if (r_i == r_n - 1'b1) r_st <= S_IDLE;
                        else begin
                            r_i <= r_i + 1'b1;
                            r_raddr <= {r_bank, r_i + 1'b1};
                            r_st <= S_ORD;
                        end
                    end
                end
                S_NONE: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov <= 1'b1;
                        r_res.char_out  <= 8'd0;
                        r_res.last_out  <= 1'b1;
                        r_res.no_answer <= 1'b1;
                        r_res.overflow  <= r_ovf;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/nlp_load.sv
// Front end: stores incoming bytes into a bank and queues a command per string.
// Depends on nlp_pkg and nlp_if.
module nlp_load import nlp_pkg::*; #(
    parameter int MAX_LEN = 64,
    parameter int AW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    nlp_if.sink           i_in,
    output logic          o_wr_en,
    output logic          o_wr_bank,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    input  logic          i_wr_busy,
    input  logic          i_cmd_pop,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd
);
    // Two-entry command queue; each entry owns one memory bank until popped.
    t_cmd       r_q [0:1];
    logic [1:0] r_cnt;
    logic       r_rp, r_wp;
    logic [6:0] r_len;
    logic       r_ovf;
    logic       w_acc, w_push, w_full;

    assign w_full = (r_len >= 7'(MAX_LEN));
    // hold off while the queue is full or the engine uses the memory write port
    assign i_in.ready = (r_cnt != 2'd2) && !i_wr_busy;
    assign w_acc  = i_in.valid && i_in.ready;
    assign w_push = w_acc && i_in.data.last_in;
    assign o_wr_en   = w_acc && !w_full;
    assign o_wr_bank = r_wp;
    assign o_wr_addr = r_len[AW-1:0];
    assign o_wr_data = i_in.data.char_in;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp].len  <= w_full ? r_len : r_len + 7'd1;
            r_q[r_wp].ovf  <= r_ovf || w_full;
            r_q[r_wp].bank <= r_wp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_rp <= 1'b0; r_wp <= 1'b0;
            r_len <= '0; r_ovf <= 1'b0;
        end else begin
            if (w_acc) begin
                if (w_push) begin
                    r_len <= '0; r_ovf <= 1'b0; r_wp <= !r_wp;
                end else if (w_full) r_ovf <= 1'b1;
                else r_len <= r_len + 7'd1;
            end
            if (i_cmd_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_cmd_pop};
        end
    end
endmodule

>>> hw/rtl/next_lexicographic_permutation.sv
// Next lexicographic permutation: byte stream in, next permutation out.
// Input channel carries char_in/last_in; output carries char_out, last_out,
// no_answer and overflow. A string of n bytes loads at one byte per cycle,
// unless the queue is full or the engine is writing, into one of two memory
// banks, so the next string loads while the previous one is processed. After
// the last byte the engine scans the string from the end for the pivot,
// scans for the swap partner, swaps, reverses the suffix and emits the
// result bytes one at a time. The memory has a single read port.
// The loader pauses for each cycle in which the engine writes the memory.
// Bytes past MAX_LEN are dropped and all results carry overflow.
// A string with no greater permutation yields one no_answer result.
// Reset clears the loader, the command queue and the engine; memory keeps
// its contents. If the receiver stalls, the engine holds its result and
// the loader keeps taking bytes until both banks are full.
// Depends on nlp_pkg, nlp_if, nlp_load and nlp_eng.
module next_lexicographic_permutation import nlp_pkg::*; #(
    parameter int MAX_LEN = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    nlp_if.sink   i_in,
    nlp_if.source o_out
);
    localparam int AW = $clog2(MAX_LEN + 1);
    logic          w_wr_en, w_wr_bank, w_pop, w_cmd_valid, w_wr_busy;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    t_cmd          w_cmd;

    nlp_load #(.MAX_LEN(MAX_LEN), .AW(AW)) u_load (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_wr_en(w_wr_en), .o_wr_bank(w_wr_bank), .o_wr_addr(w_wr_addr),
        .o_wr_data(w_wr_data), .i_wr_busy(w_wr_busy), .i_cmd_pop(w_pop),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd)
    );

    nlp_eng #(.AW(AW)) u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_en(w_wr_en), .i_wr_bank(w_wr_bank), .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data), .o_wr_busy(w_wr_busy),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_pop(w_pop), .o_res(o_out)
    );
endmodule

>>> verif/next_lexicographic_permutation_tb.sv
// Testbench for next_lexicographic_permutation: byte strings in, next
// permutation out, checked against an in-bench predictor via a scoreboard.
// Depends on nlp_pkg, nlp_if and the RTL top level.
`timescale 1ns / 1ps

module next_lexicographic_permutation_tb;
    import nlp_pkg::*;

    localparam int MAX_LEN = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    class perm_scoreboard;
        logic [7:0] pending_bytes[$];
        bit         pending_ovf;
        t_out       expected_q[$];
        int         mismatches;

        function void note_byte(t_in item);
            logic [7:0] s[$];
            int n, pivot, partner, lo, hi;
            logic [7:0] tmp;
            t_out r;
            if (pending_bytes.size() < MAX_LEN) pending_bytes.push_back(item.char_in);
            else pending_ovf = 1'b1;
            if (!item.last_in) return;
            s = pending_bytes;
            n = s.size();
            pivot = -1;
            for (int k = n - 2; k >= 0; k--) begin
                if (s[k] < s[k + 1]) begin
                    pivot = k;
                    break;
                end
            end
            if (pivot < 0) begin
                r.char_out = 8'd0;
                r.last_out = 1'b1;
                r.no_answer = 1'b1;
                r.overflow = pending_ovf;
                expected_q.push_back(r);
            end else begin
                partner = n - 1;
                while (s[partner] <= s[pivot]) partner--;
                tmp = s[pivot];
                s[pivot] = s[partner];
                s[partner] = tmp;
                lo = pivot + 1;
                hi = n - 1;
                while (lo < hi) begin
                    tmp = s[lo];
                    s[lo] = s[hi];
                    s[hi] = tmp;
                    lo++;
                    hi--;
                end
                for (int k = 0; k < n; k++) begin
                    r.char_out = s[k];
                    r.last_out = (k == n - 1);
                    r.no_answer = 1'b0;
                    r.overflow = pending_ovf;
                    expected_q.push_back(r);
                end
            end
            pending_bytes.delete();
            pending_ovf = 1'b0;
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h/%b/%b/%b", got.char_out,
                             got.last_out, got.no_answer, got.overflow);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                             want.char_out, want.last_out, want.no_answer,
                             want.overflow, got.char_out, got.last_out,
                             got.no_answer, got.overflow);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    nlp_if #(.T(t_in))  in_ch ();
    nlp_if #(.T(t_out)) out_ch ();

    next_lexicographic_permutation #(.MAX_LEN(MAX_LEN)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    perm_scoreboard sb;
    int  idle_cycles;
    bit  stim_done;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // Count cycles with no accepted transaction to watch for a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end

    // Receiver: random stall before each result, sometimes none.
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] ch, input bit last, input bit no_gap);
        t_in item;
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item.char_in = ch;
        item.last_in = last;
        in_ch.data <= item;
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_byte(item);
    endtask

    task automatic send_string(input logic [7:0] s[$], input bit no_gap);
        for (int k = 0; k < s.size(); k++)
            send_byte(s[k], k == s.size() - 1, no_gap);
    endtask

    task automatic send_random_string(input int len, input int alphabet, input bit no_gap);
        logic [7:0] s[$];
        logic [7:0] base;
        base = 8'($urandom_range(0, 255 - alphabet));
        for (int k = 0; k < len; k++) s.push_back(8'(base + $urandom_range(0, alphabet)));
        send_string(s, no_gap);
    endtask

    initial begin
        int sent;
        int len;
        logic [7:0] s[$];
        sb = new();
        stim_done = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single byte, extremes, equal bytes, descending, ascending.
        send_byte(8'h00, 1'b1, 1'b0);
        s = '{8'hFF, 8'h00};                send_string(s, 1'b0);
        s = '{8'h00, 8'hFF};                send_string(s, 1'b0);
        s = '{8'h55, 8'h55, 8'h55};         send_string(s, 1'b0);
        s = '{8'h01, 8'h02, 8'h02, 8'h01};  send_string(s, 1'b0);
        s = '{8'hAA, 8'h55, 8'h80, 8'h7F};  send_string(s, 1'b1);
        s = '{8'h03, 8'h02, 8'h01};         send_string(s, 1'b0);
        s = '{8'h01, 8'h02, 8'h03};         send_string(s, 1'b0);
        // Overflow: capacity plus extra bytes, last one dropped too; then a full-length descending string.
        s.delete();
        for (int k = 0; k < MAX_LEN + 2; k++) s.push_back(k[7:0]);
        send_string(s, 1'b1);
        s.delete();
        for (int k = 0; k < MAX_LEN; k++) s.push_back(8'hFF - k[7:0]);
        send_string(s, 1'b0);

        // Directed strings above carry about 150 bytes; random ones add at least 200 more.
        sent = 0;
        while (sent < 200) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(MAX_LEN - 1, MAX_LEN + 3);
                1:       len = 1;
                default: len = $urandom_range(2, 8);
            endcase
            send_random_string(len, ($urandom_range(0, 1) ? 3 : 255),
                               $urandom_range(0, 4) == 0);
            sent += len;
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
            if (stim_done && sb.expected_q.size() == 0) begin
                repeat (1200) @(posedge i_clk);
                if (sb.mismatches == 0 && sb.expected_q.size() == 0)
                    $display("status: pass");
                else
                    $display("status: fail");
                $finish;
            end
        end
    end
endmodule

>>> sim.f
hw/rtl/nlp_pkg.sv
hw/rtl/nlp_if.sv
hw/rtl/nlp_eng.sv
hw/rtl/nlp_load.sv
hw/rtl/next_lexicographic_permutation.sv
verif/next_lexicographic_permutation_tb.sv
